### hw/rtl/sfhs_pkg.sv
// ----------------------------------------------------------------------------
// sfhs_pkg
// Shared types and constants for the stepper full/half step sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package sfhs_pkg;

   // Field widths
   localparam int CMD_W      = 2;
   localparam int STEPS_W    = 24;
   localparam int DELAY_W    = 16;
   localparam int PAUSE_W    = 9;
   localparam int PHASE_W    = 3;
   localparam int COIL_W     = 4;

   // Pause boundary: count is a multiple of 2**bits
   localparam int FULL_PERIOD_BITS = 11;  // 2048
   localparam int HALF_PERIOD_BITS = 12;  // 4096

   // Register port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_LSB = 2;
   localparam logic [DELAY_W-1:0] DELAY_RESET = 16'd100;

   // Register indexes
   typedef enum logic {
      REG_STEP_DELAY = 1'b0
   } reg_idx_type;

   // Request commands
   typedef enum logic [CMD_W-1:0] {
      CMD_TICK  = 2'd0,
      CMD_START = 2'd1,
      CMD_STOP  = 2'd2
   } cmd_type;

   // Coil tables, bit0 is the first coil
   localparam logic [COIL_W-1:0] FULL_TABLE [4] = '{4'h3, 4'h6, 4'hC, 4'h9};
   localparam logic [COIL_W-1:0] HALF_TABLE [8] =
      '{4'h1, 4'h3, 4'h2, 4'h6, 4'h4, 4'hC, 4'h8, 4'h9};

   // One request as held in the input register
   typedef struct packed {
      logic [CMD_W-1:0]   command;
      logic [STEPS_W-1:0] steps;
      logic               direction;
      logic               half_mode;
   } req_item_type;

   // One response
   typedef struct packed {
      logic [COIL_W-1:0] coils;
      logic              busy_res;
      logic              stepped;
   } rsp_item_type;

endpackage

`default_nettype wire

### hw/rtl/sfhs_csr.sv
// ----------------------------------------------------------------------------
// sfhs_csr
// APB-style register port holding the step delay.
// ----------------------------------------------------------------------------
`default_nettype none

module sfhs_csr
   import sfhs_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic      [CSR_DATA_W-1:0] csr_prdata,
   output logic                       csr_pready,
   output logic      [DELAY_W-1:0]    ticks_per_step
);

   logic [DELAY_W-1:0] ticks_per_step_ff, ticks_per_step_in;
   reg_idx_type        reg_idx;
   logic               wr_en;

   assign reg_idx    = reg_idx_type'(csr_paddr[CSR_IDX_LSB]);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   // Register write
   always_comb begin
      ticks_per_step_in = ticks_per_step_ff;
      if (wr_en && reg_idx == REG_STEP_DELAY) begin
         ticks_per_step_in = csr_pwdata[DELAY_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ticks_per_step_ff <= DELAY_RESET;
      end else begin
         ticks_per_step_ff <= ticks_per_step_in;
      end
   end

   // Read back
   always_comb begin
      unique case (reg_idx)
         REG_STEP_DELAY: csr_prdata = {{(CSR_DATA_W-DELAY_W){1'b0}}, ticks_per_step_ff};
         default:        csr_prdata = '0;
      endcase
   end

   assign ticks_per_step = ticks_per_step_ff;

endmodule

`default_nettype wire

### hw/rtl/sfhs_core.sv
// ----------------------------------------------------------------------------
// sfhs_core
// Move state and the one-pass update for each tick, start or stop request.
// ----------------------------------------------------------------------------
`default_nettype none

module sfhs_core
   import sfhs_pkg::*;
#(
   parameter int STEP_COUNT_WIDTH = 24,
   parameter int PAUSE_TICKS      = 500
)(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               fire,
   input  wire req_item_type       item,
   input  wire logic [DELAY_W-1:0] ticks_per_step,
   output rsp_item_type            result
);

   logic [PHASE_W-1:0]          phase_ff, phase_in;
   logic [STEP_COUNT_WIDTH-1:0] remain_ff, remain_in;
   logic [DELAY_W-1:0]          delay_ff, delay_in;
   logic [PAUSE_W-1:0]          pause_ff, pause_in;
   logic                        pausing_ff, pausing_in;
   logic                        running_ff, running_in;
   logic                        half_ff, half_in;
   logic                        dir_ff, dir_in;
   logic [COIL_W-1:0]           coil_ff, coil_in;

   logic [STEP_COUNT_WIDTH-1:0] steps_ext;
   logic [STEP_COUNT_WIDTH-1:0] remain_dec;
   logic [DELAY_W:0]            delay_next;
   logic [PHASE_W-1:0]          phase_step;
   logic [COIL_W-1:0]           coil_step;
   logic                        at_boundary;
   logic                        stepped;
   cmd_type                     cmd;

   assign cmd        = cmd_type'(item.command);
   assign steps_ext  = STEP_COUNT_WIDTH'(item.steps);
   assign remain_dec = remain_ff - STEP_COUNT_WIDTH'(1);
   assign delay_next = {1'b0, delay_ff} + (DELAY_W+1)'(1);

   // Next phase and its coil pattern
   always_comb begin
      if (half_ff) begin
         phase_step  = dir_ff ? phase_ff + PHASE_W'(1) : phase_ff - PHASE_W'(1);
         coil_step   = HALF_TABLE[phase_step];
         at_boundary = (remain_ff[HALF_PERIOD_BITS-1:0] == '0);
      end else begin
         phase_step  = {1'b0, dir_ff ? phase_ff[1:0] + 2'd1 : phase_ff[1:0] - 2'd1};
         coil_step   = FULL_TABLE[phase_step[1:0]];
         at_boundary = (remain_ff[FULL_PERIOD_BITS-1:0] == '0);
      end
   end

   // Request update
   always_comb begin
      phase_in   = phase_ff;
      remain_in  = remain_ff;
      delay_in   = delay_ff;
      pause_in   = pause_ff;
      pausing_in = pausing_ff;
      running_in = running_ff;
      half_in    = half_ff;
      dir_in     = dir_ff;
      coil_in    = coil_ff;
      stepped    = 1'b0;
      if (fire) begin
         unique case (cmd)
            CMD_START: begin
               remain_in  = steps_ext;
               dir_in     = item.direction;
               half_in    = item.half_mode;
               phase_in   = '0;
               delay_in   = '0;
               pause_in   = '0;
               pausing_in = 1'b0;
               running_in = (steps_ext != '0);
            end
            CMD_STOP: begin
               remain_in  = '0;
               delay_in   = '0;
               pause_in   = '0;
               pausing_in = 1'b0;
               running_in = 1'b0;
               coil_in    = '0;
            end
            CMD_TICK: begin
               if (running_ff && pausing_ff) begin
                  // pause countdown; the final tick makes no step
                  if (pause_ff <= PAUSE_W'(1)) begin
                     pause_in   = '0;
                     pausing_in = 1'b0;
                     delay_in   = '0;
                     if (remain_ff == '0) begin
                        running_in = 1'b0;
                     end
                  end else begin
                     pause_in = pause_ff - PAUSE_W'(1);
                  end
               end else if (running_ff) begin
                  if (delay_next >= {1'b0, ticks_per_step}) begin
                     delay_in  = '0;
                     phase_in  = phase_step;
                     coil_in   = coil_step;
                     remain_in = remain_dec;
                     stepped   = 1'b1;
                     if (at_boundary) begin
                        pausing_in = 1'b1;
                        pause_in   = PAUSE_W'(PAUSE_TICKS);
                     end else if (remain_dec == '0) begin
                        running_in = 1'b0;
                     end
                  end else begin
                     delay_in = delay_next[DELAY_W-1:0];
                  end
               end
            end
            default: begin
               // unused code: state unchanged
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= '0;
         remain_ff  <= '0;
         delay_ff   <= '0;
         pause_ff   <= '0;
         pausing_ff <= 1'b0;
         running_ff <= 1'b0;
         half_ff    <= 1'b0;
         dir_ff     <= 1'b0;
         coil_ff    <= '0;
      end else begin
         phase_ff   <= phase_in;
         remain_ff  <= remain_in;
         delay_ff   <= delay_in;
         pause_ff   <= pause_in;
         pausing_ff <= pausing_in;
         running_ff <= running_in;
         half_ff    <= half_in;
         dir_ff     <= dir_in;
         coil_ff    <= coil_in;
      end
   end

   // Response reflects the updated state
   assign result.coils    = coil_in;
   assign result.busy_res = running_in;
   assign result.stepped  = stepped;

   // A pause only exists inside a running move
   a_pause_in_move: assert property (@(posedge clock) disable iff (reset)
      pausing_ff |-> running_ff)
      else $error("pause outside a move");

   // Pause counter is live exactly while pausing
   a_pause_count: assert property (@(posedge clock) disable iff (reset)
      pausing_ff == (pause_ff != '0))
      else $error("pause counter out of step with pause flag");

   // Idle means nothing left to do
   a_idle_empty: assert property (@(posedge clock) disable iff (reset)
      !running_ff |-> (remain_ff == '0 && !pausing_ff))
      else $error("idle with steps left");

   // Full-step mode keeps the phase inside four entries
   a_full_phase: assert property (@(posedge clock) disable iff (reset)
      !half_ff |-> !phase_ff[PHASE_W-1])
      else $error("full-step phase out of range");

   // A step only comes from a running, unpaused move
   a_step_source: assert property (@(posedge clock) disable iff (reset)
      stepped |-> (running_ff && !pausing_ff && fire))
      else $error("step without an active move");

endmodule

`default_nettype wire

### hw/rtl/stepper_full_half_step_sequencer.sv
// ----------------------------------------------------------------------------
// stepper_full_half_step_sequencer
// Four-coil stepper sequencer, full-step or half-step, driven by 1 ms ticks.
// ----------------------------------------------------------------------------
// Usage:
//   req_ channel carries one request per handshake: a tick, a start (with
//   step count, direction and mode) or a stop. rsp_ channel returns one
//   response per request: coil pattern, busy flag and a stepped flag.
//   csr_ port holds the step delay (ticks per step) at byte address 0.
// Path: an accepted request is held in the input register, makes one
//   update pass, and its response is held in the response register.
// Throughput: one request per cycle while rsp_ready is high; the state
//   update between the input and response registers is combinational.
// Reset: all coils off, no move, step delay back to 100 ticks.
// Stall: when a response waits and rsp_ready is low, the response register
//   holds; the input register still takes one more request, then req_ready
//   drops until the response is taken. No request is lost or repeated.
// Write the step delay only while no requests are in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module stepper_full_half_step_sequencer
   import sfhs_pkg::*;
#(
   parameter int STEP_COUNT_WIDTH = 24,
   parameter int PAUSE_TICKS      = 500
)(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // request channel
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [CMD_W-1:0]      req_command,
   input  wire logic [STEPS_W-1:0]    req_steps,
   input  wire logic                  req_direction,
   input  wire logic                  req_half_mode,
   // response channel
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic      [COIL_W-1:0]     rsp_coils,
   output logic                       rsp_busy_res,
   output logic                       rsp_stepped,
   // register port
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic      [CSR_DATA_W-1:0] csr_prdata,
   output logic                       csr_pready
);

   logic               in_valid_ff, in_valid_in;
   req_item_type       in_item_ff, in_item_in;
   logic               out_valid_ff, out_valid_in;
   rsp_item_type       out_item_ff, out_item_in;
   rsp_item_type       result;
   logic [DELAY_W-1:0] ticks_per_step;
   logic               advance;
   logic               req_fire;

   // Registers
   sfhs_csr u_csr (
      .clock          (clock),
      .reset          (reset),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready),
      .ticks_per_step (ticks_per_step)
   );

   // Handshake control
   assign advance   = !out_valid_ff || rsp_ready;
   assign req_ready = !in_valid_ff || advance;
   assign req_fire  = req_valid && req_ready;

   // Input register
   always_comb begin
      in_valid_in = in_valid_ff;
      in_item_in  = in_item_ff;
      if (req_fire) begin
         in_valid_in       = 1'b1;
         in_item_in.command   = req_command;
         in_item_in.steps     = req_steps;
         in_item_in.direction = req_direction;
         in_item_in.half_mode = req_half_mode;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      in_item_ff <= in_item_in;
   end

   // State update
   sfhs_core #(
      .STEP_COUNT_WIDTH (STEP_COUNT_WIDTH),
      .PAUSE_TICKS      (PAUSE_TICKS)
   ) u_core (
      .clock          (clock),
      .reset          (reset),
      .fire           (in_valid_ff && advance),
      .item           (in_item_ff),
      .ticks_per_step (ticks_per_step),
      .result         (result)
   );

   // Response register
   always_comb begin
      out_valid_in = out_valid_ff;
      out_item_in  = out_item_ff;
      if (advance) begin
         out_valid_in = in_valid_ff;
         out_item_in  = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      out_item_ff <= out_item_in;
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_coils    = out_item_ff.coils;
   assign rsp_busy_res = out_item_ff.busy_res;
   assign rsp_stepped  = out_item_ff.stepped;

   // A held request waits while the response is stalled
   a_in_hold: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> (in_valid_ff && $stable(in_item_ff)))
      else $error("held request lost");

   // Request register can only be refilled when it empties or moves on
   a_ready_rule: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && out_valid_ff && !rsp_ready) |-> !req_ready)
      else $error("request taken while both stages full");

   // A stalled response does not change
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_ready) |=> (out_valid_ff && $stable(out_item_ff)))
      else $error("stalled response changed");

endmodule

`default_nettype wire
